// ----- rtl/core/literal_expression_calculator_defines.svh -----
// ----------------------------------------------------------------------------
// Literal expression calculator assertion macros
// Shared concurrent assertion forms for the calculator RTL.
// ----------------------------------------------------------------------------
`ifndef LITERAL_EXPRESSION_CALCULATOR_DEFINES_SVH
`define LITERAL_EXPRESSION_CALCULATOR_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define LEC_ASSERT_IMP(lbl, clk_s, rstn_s, cond, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define LEC_ASSERT_NEXT(lbl, clk_s, rstn_s, cond, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/lec_pkg.sv -----
// ----------------------------------------------------------------------------
// Literal expression calculator package
// Operator, number kind and status codes plus controller/datapath structs.
// ----------------------------------------------------------------------------
package lec_pkg;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_SHL     = 4'd1,
        OP_SHR     = 4'd2,
        OP_OR      = 4'd3,
        OP_AND     = 4'd4,
        OP_XOR     = 4'd5,
        OP_MOD     = 4'd6,
        OP_ADD     = 4'd7,
        OP_SUB     = 4'd8,
        OP_MUL     = 4'd9,
        OP_DIV     = 4'd10,
        OP_WAIT_LT = 4'd11,
        OP_WAIT_GT = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        KIND_DEC  = 2'd0,
        KIND_BIN  = 2'd1,
        KIND_HEX  = 2'd2,
        KIND_ZERO = 2'd3
    } kind_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_COUNT   = 3'd1;
    localparam logic [2:0] ST_FIRST   = 3'd2;
    localparam logic [2:0] ST_OPER    = 3'd3;
    localparam logic [2:0] ST_SECOND  = 3'd4;
    localparam logic [2:0] ST_DIVZERO = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [6:0] POS_MAX  = 7'd127;

    // Commands from controller to datapath
    typedef struct packed {
        logic scan;     // consume the input beat in the front end
        logic close;    // feed a separator to close a trailing token
        logic start;    // launch evaluation with current state
        logic step;     // advance one iteration of the multiply/divide unit
        logic clear;    // return expression state to reset values
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic need_div;  // expression requires the iterative multiply/divide unit
        logic div_done;  // iterative unit is taking its last step
    } dp_stat_t;

endpackage

// ----- rtl/core/literal_expression_calculator.sv -----
// Result valid after the close and evaluate states after the last character;
//   *, / and % add S_DIV (one shift-add or radix-2 divider step per cycle).
// Throughput: one character per cycle while scanning; none from the last
//   beat until the result beat has been taken.
// Reset: rst_n asynchronous active low clears all token and control state.
// ----------------------------------------------------------------------------
// Literal expression calculator
// Parses number [operator number] text and produces a signed 64-bit result.
// ----------------------------------------------------------------------------
module literal_expression_calculator #(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [66:64] status, rest zero
);

    lec_pkg::dp_cmd_t  cmd;
    lec_pkg::dp_stat_t stat;
    logic [63:0]       value;
    logic [2:0]        status;
    logic [7:0]        char_in;

    lec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // On the cycle after the last beat the controller asks for a close pass:
    // feed a space through the scanner so that a trailing token is finished
    // before evaluation starts.
    assign char_in = cmd.close ? lec_pkg::CH_SPACE : s_tdata;

    lec_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_in),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .status    (status)
    );

    assign m_tdata = {5'd0, status, value};

endmodule

// ----- rtl/core/lec_ctrl.sv -----
// ----------------------------------------------------------------------------
// Literal expression calculator controller
// Sequences character scanning, evaluation and result hand-off.
// ----------------------------------------------------------------------------
`include "literal_expression_calculator_defines.svh"

module lec_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lec_pkg::dp_cmd_t      cmd,
    input  lec_pkg::dp_stat_t     stat
);

    typedef enum logic [4:0] {
        S_SCAN  = 5'b00001,
        S_CLOSE = 5'b00010,
        S_EVAL  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic acc_last;

    assign in_ready  = (state_reg == S_SCAN);
    assign out_valid = (state_reg == S_OUT);
    assign acc_last  = in_valid && in_ready && in_last;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.scan   = in_valid && in_ready;
        case (state_reg)
            S_SCAN:
            begin
                if (acc_last)
                    state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.start  = 1'b1;
                state_next = stat.need_div ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            default: state_next = S_SCAN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_SCAN;
        else
            state_reg <= state_next;
    end

    `LEC_ASSERT_NEXT(a_last_closes, clk, rst_n, acc_last, state_reg == S_CLOSE)
    `LEC_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `LEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `LEC_ASSERT_IMP(a_no_both, clk, rst_n, in_ready, !out_valid)

endmodule

// ----- rtl/core/lec_dp.sv -----
// ----------------------------------------------------------------------------
// Literal expression calculator datapath
// Token scanner, operand registers, ALU, shift-add multiplier and radix-2
// divider.
// ----------------------------------------------------------------------------
module lec_dp #(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            char_code,
    input  lec_pkg::dp_cmd_t      cmd,
    output lec_pkg::dp_stat_t     stat,
    output logic [63:0]           value,
    output logic [2:0]            status
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [2:0]             tok_cnt_reg;
    logic                   in_tok_reg;
    logic [6:0]             pos_reg;
    lec_pkg::kind_t         kind_reg;
    logic                   tok_ok_reg;
    logic                   neg_reg;
    logic [W-1:0]           acc_reg;
    logic [W-1:0]           left_reg;
    lec_pkg::op_t           op_reg;
    logic [7:0]             first_reg;
    logic [2:0]             perr_reg;

    logic [63:0]            value_reg;
    logic [2:0]             status_reg;

    // multiply/divide unit
    logic [W-1:0]           dq_reg, dr_reg, dd_reg;
    logic [CW-1:0]          dcnt_reg;
    logic                   dneg_q_reg, dneg_r_reg, dmod_reg, dmul_reg;

    // scanner next values
    logic [2:0]             tc;
    logic                   it;
    logic [6:0]             ps;
    lec_pkg::kind_t         kd;
    logic                   ok;
    logic                   ng;
    logic [W-1:0]           ac;
    logic [W-1:0]           lf;
    lec_pkg::op_t           op;
    logic [7:0]             fc;
    logic [2:0]             pe;

    logic                   is_sep, sgn, dig, hexd;
    logic [3:0]             nib;
    logic [W-1:0]           num_val;
    logic                   num_ok;

    assign value  = value_reg;
    assign status = status_reg;

    function automatic logic [W-1:0] sext_dummy(input logic [W-1:0] v);
        sext_dummy = v;
    endfunction

    // Validate the current token as a number; value with sign applied
    always_comb
    begin
        logic [W-1:0] t;
        logic         s;
        s      = (first_reg == "-") || (first_reg == "+");
        num_ok = tok_ok_reg;
        case (kind_reg)
            lec_pkg::KIND_DEC:  num_ok = num_ok && (pos_reg > (s ? 7'd1 : 7'd0));
            lec_pkg::KIND_BIN:  num_ok = num_ok && (pos_reg >= 7'd3)
                                    && ({25'd0, pos_reg} <= 32'(W + 2));
            lec_pkg::KIND_HEX:  num_ok = num_ok && (pos_reg >= 7'd3);
            default:            num_ok = num_ok;
        endcase
        t       = (kind_reg == lec_pkg::KIND_ZERO) ? '0 : acc_reg;
        num_val = neg_reg ? (~t + 1'b1) : t;
    end

    always_comb
    begin
        tc = tok_cnt_reg; it = in_tok_reg; ps = pos_reg; kd = kind_reg;
        ok = tok_ok_reg;  ng = neg_reg;    ac = acc_reg; lf = left_reg;
        op = op_reg;      fc = first_reg;  pe = perr_reg;
        is_sep = (char_code == lec_pkg::CH_SPACE) || (char_code == lec_pkg::CH_NL);
        sgn    = (first_reg == "-") || (first_reg == "+");
        dig    = (char_code >= "0") && (char_code <= "9");
        hexd   = 1'b1;
        nib    = 4'd0;
        if (dig)
            nib = 4'(char_code - "0");
        else if (char_code >= "a" && char_code <= "f")
            nib = 4'(char_code - "a" + 8'd10);
        else if (char_code >= "A" && char_code <= "F")
            nib = 4'(char_code - "A" + 8'd10);
        else
            hexd = 1'b0;

        if (is_sep)
        begin
            if (in_tok_reg)
            begin
                // close token
                if (tok_cnt_reg == 3'd1)
                begin
                    if (num_ok)
                        lf = num_val;
                    else if (pe == lec_pkg::ST_OK)
                        pe = lec_pkg::ST_FIRST;
                end
                else if (tok_cnt_reg == 3'd2)
                begin
                    if ((op_reg == lec_pkg::OP_NONE || op_reg >= lec_pkg::OP_WAIT_LT)
                        && pe == lec_pkg::ST_OK)
                        pe = lec_pkg::ST_OPER;
                end
                else if (tok_cnt_reg == 3'd3)
                begin
                    ac = num_val;
                    if (!num_ok && pe == lec_pkg::ST_OK)
                        pe = lec_pkg::ST_SECOND;
                end
                it = 1'b0;
            end
        end
        else
        begin
            if (!in_tok_reg)
            begin
                it = 1'b1;
                if (tok_cnt_reg < 3'd4)
                    tc = tok_cnt_reg + 3'd1;
                ps = '0; kd = lec_pkg::KIND_DEC; ok = 1'b1; ng = 1'b0;
                ac = '0; fc = '0;
            end
            if (tc == 3'd1 || tc == 3'd3)
            begin
                if (ok)
                begin
                    if (ps == 7'd0)
                    begin
                        fc = char_code;
                        if (char_code == "-" || char_code == "+")
                        begin
                            ng = (char_code == "-");
                            kd = lec_pkg::KIND_DEC;
                        end
                        else if (char_code == "0")
                            kd = lec_pkg::KIND_ZERO;
                        else if (dig)
                        begin
                            kd = lec_pkg::KIND_DEC;
                            ac = W'(char_code - "0");
                        end
                        else
                            ok = 1'b0;
                    end
                    else
                    begin
                        case (kd)
                            lec_pkg::KIND_DEC:
                            begin
                                if (dig)
                                begin
                                    if (ps == 7'd1 && sgn && char_code == "0")
                                        kd = lec_pkg::KIND_ZERO;
                                    else
                                        ac = (ac << 3) + (ac << 1) + W'(nib);
                                end
                                else
                                    ok = 1'b0;
                            end
                            lec_pkg::KIND_ZERO:
                            begin
                                if (ps == 7'd1 && fc == "0"
                                    && (char_code == "b" || char_code == "B"))
                                    kd = lec_pkg::KIND_BIN;
                                else if (ps == 7'd1 && fc == "0"
                                    && (char_code == "x" || char_code == "X"))
                                    kd = lec_pkg::KIND_HEX;
                                else
                                    ok = 1'b0;
                            end
                            lec_pkg::KIND_BIN:
                            begin
                                if (char_code == "0" || char_code == "1")
                                    ac = {ac[W-2:0], char_code[0]};
                                else
                                    ok = 1'b0;
                            end
                            default:
                            begin
                                if (hexd)
                                    ac = {ac[W-5:0], nib};
                                else
                                    ok = 1'b0;
                            end
                        endcase
                    end
                end
            end
            else if (tc == 3'd2)
            begin
                if (ps == 7'd0)
                begin
                    case (char_code)
                        "<":     op = lec_pkg::OP_WAIT_LT;
                        ">":     op = lec_pkg::OP_WAIT_GT;
                        "|":     op = lec_pkg::OP_OR;
                        "&":     op = lec_pkg::OP_AND;
                        "^":     op = lec_pkg::OP_XOR;
                        "%":     op = lec_pkg::OP_MOD;
                        "+":     op = lec_pkg::OP_ADD;
                        "-":     op = lec_pkg::OP_SUB;
                        "*":     op = lec_pkg::OP_MUL;
                        "/":     op = lec_pkg::OP_DIV;
                        default: op = lec_pkg::OP_NONE;
                    endcase
                end
                else if (ps == 7'd1)
                begin
                    if (op == lec_pkg::OP_WAIT_LT && char_code == "<")
                        op = lec_pkg::OP_SHL;
                    else if (op == lec_pkg::OP_WAIT_GT && char_code == ">")
                        op = lec_pkg::OP_SHR;
                end
            end
            if (ps < lec_pkg::POS_MAX)
                ps = ps + 7'd1;
        end
    end

    // Evaluation: operands after the last token has been closed
    logic [W-1:0] a, b, ua, ub, r, sra;
    logic         na, nb, big;
    logic [2:0]   st;

    assign a   = left_reg;
    assign b   = acc_reg;
    assign na  = a[W-1];
    assign nb  = b[W-1];
    assign ua  = na ? (~a + 1'b1) : a;
    assign ub  = nb ? (~b + 1'b1) : b;
    assign big = (b >= W'(W));
    assign sra = $signed(a) >>> b[CW-1:0];

    always_comb
    begin
        r  = '0;
        st = lec_pkg::ST_OK;
        if (tok_cnt_reg != 3'd1 && tok_cnt_reg != 3'd3)
            st = lec_pkg::ST_COUNT;
        else if (perr_reg != lec_pkg::ST_OK)
            st = perr_reg;
        else if (tok_cnt_reg == 3'd1)
            r = a;
        else
        begin
            case (op_reg)
                lec_pkg::OP_SHL: r = big ? '0 : (a << b[CW-1:0]);
                lec_pkg::OP_SHR: r = big ? {W{na}} : sra;
                lec_pkg::OP_OR:  r = a | b;
                lec_pkg::OP_AND: r = a & b;
                lec_pkg::OP_XOR: r = a ^ b;
                lec_pkg::OP_ADD: r = a + b;
                lec_pkg::OP_SUB: r = a - b;
                // product comes from the iterative unit
                lec_pkg::OP_MUL: r = '0;
                default:
                    if (ub == '0)
                        st = lec_pkg::ST_DIVZERO;
            endcase
        end
    end

    logic div_go;
    assign div_go = (st == lec_pkg::ST_OK) && (tok_cnt_reg == 3'd3)
        && (op_reg == lec_pkg::OP_DIV || op_reg == lec_pkg::OP_MOD
            || op_reg == lec_pkg::OP_MUL);
    assign stat.need_div = div_go;
    assign stat.div_done = (dcnt_reg == CW'(1));

    // one restoring division step
    logic [W:0]   trial;
    logic [W-1:0] rsh;
    assign rsh   = {dr_reg[W-2:0], dq_reg[W-1]};
    assign trial = {1'b0, rsh} - {1'b0, dd_reg};

    // one shift-add multiply step: dq holds the multiplier, dd the multiplicand
    logic [W-1:0] madd;
    assign madd = dr_reg + (dq_reg[0] ? dd_reg : '0);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dq_reg     <= (op_reg == lec_pkg::OP_MUL) ? b : ua;
            dr_reg     <= '0;
            dd_reg     <= (op_reg == lec_pkg::OP_MUL) ? a : ub;
            dneg_q_reg <= na ^ nb;
            dneg_r_reg <= na;
            dmod_reg   <= (op_reg == lec_pkg::OP_MOD);
            dmul_reg   <= (op_reg == lec_pkg::OP_MUL);
        end
        else if (cmd.step)
        begin
            if (dmul_reg)
            begin
                dr_reg <= madd;
                dd_reg <= {dd_reg[W-2:0], 1'b0};
                dq_reg <= {1'b0, dq_reg[W-1:1]};
            end
            else
            begin
                dr_reg <= trial[W] ? rsh : trial[W-1:0];
                dq_reg <= {dq_reg[W-2:0], ~trial[W]};
            end
        end
    end

    logic [W-1:0] dres, qn, rn;
    always_comb
    begin
        rn   = trial[W] ? rsh : trial[W-1:0];
        qn   = {dq_reg[W-2:0], ~trial[W]};
        if (dmul_reg)
            dres = madd;
        else if (dmod_reg)
            dres = dneg_r_reg ? (~rn + 1'b1) : rn;
        else
            dres = dneg_q_reg ? (~qn + 1'b1) : qn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_cnt_reg <= '0; in_tok_reg <= 1'b0; pos_reg <= '0;
            kind_reg <= lec_pkg::KIND_DEC; tok_ok_reg <= 1'b1; neg_reg <= 1'b0;
            acc_reg <= '0; left_reg <= '0; op_reg <= lec_pkg::OP_NONE;
            first_reg <= '0; perr_reg <= '0; dcnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            tok_cnt_reg <= '0; in_tok_reg <= 1'b0; pos_reg <= '0;
            kind_reg <= lec_pkg::KIND_DEC; tok_ok_reg <= 1'b1; neg_reg <= 1'b0;
            acc_reg <= '0; left_reg <= '0; op_reg <= lec_pkg::OP_NONE;
            first_reg <= '0; perr_reg <= '0; dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.scan || cmd.close)
            begin
                tok_cnt_reg <= tc; in_tok_reg <= it; pos_reg <= ps; kind_reg <= kd;
                tok_ok_reg <= ok; neg_reg <= ng; acc_reg <= ac; left_reg <= lf;
                op_reg <= op; first_reg <= fc; perr_reg <= pe;
            end
            if (cmd.start)
                dcnt_reg <= CW'(W);
            else if (cmd.step && dcnt_reg != '0)
                dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // Latch the result at evaluation, or when the iterative unit finishes.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg  <= (st == lec_pkg::ST_OK) ? 64'($signed(sext_dummy(r))) : 64'd0;
            status_reg <= st;
        end
        else if (cmd.step && stat.div_done)
        begin
            value_reg  <= 64'($signed(dres));
            status_reg <= lec_pkg::ST_OK;
        end
    end

endmodule

// ----- tb/tb_literal_expression_calculator.sv -----
// ----------------------------------------------------------------------------
// Literal expression calculator testbench
// Streams expression text into the calculator, predicts each result from a
// local parser and evaluator, and compares value and status beat by beat.
// ----------------------------------------------------------------------------
module tb_literal_expression_calculator;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tlast;   // last
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [63:0] value, [66:64] status, rest zero

    literal_expression_calculator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
    } calc_result_t;

    // Predictor state
    logic [2:0]      tok_count;
    logic            in_tok;
    logic [6:0]      tok_pos;
    lec_pkg::kind_t  num_kind;
    logic            tok_good;
    logic            neg;
    logic [63:0]     acc;
    logic [63:0]     lhs;
    lec_pkg::op_t    oper;
    logic [7:0]      lead_char;
    logic [2:0]      first_err;

    calc_result_t results_due[$];
    int  mismatches;
    int  cycles = 0;
    bit  failed;
    bit  hold_off;
    bit  calm;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic expr_reset();
        tok_count = '0;
        in_tok    = 1'b0;
        lhs       = '0;
        oper      = lec_pkg::OP_NONE;
        first_err = lec_pkg::ST_OK;
        tok_pos   = '0;
        num_kind  = lec_pkg::KIND_DEC;
        tok_good  = 1'b1;
        neg       = 1'b0;
        acc       = '0;
        lead_char = '0;
    endtask

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic scan_number_char(logic [7:0] c);
        bit signed_lead;
        int nib;
        signed_lead = (lead_char == "-" || lead_char == "+");
        if (!tok_good)
            return;
        if (tok_pos == 0)
        begin
            lead_char = c;
            if (c == "-" || c == "+")
            begin
                neg      = (c == "-");
                num_kind = lec_pkg::KIND_DEC;
            end
            else if (c == "0")
                num_kind = lec_pkg::KIND_ZERO;
            else if (c >= "1" && c <= "9")
            begin
                num_kind = lec_pkg::KIND_DEC;
                acc      = 64'(c - "0");
            end
            else
                tok_good = 1'b0;
            return;
        end
        case (num_kind)
            lec_pkg::KIND_DEC:
                if (c >= "0" && c <= "9")
                begin
                    if (tok_pos == 1 && signed_lead && c == "0")
                        num_kind = lec_pkg::KIND_ZERO;
                    else
                        acc = acc * 10 + 64'(c - "0");
                end
                else
                    tok_good = 1'b0;
            lec_pkg::KIND_ZERO:
                if (tok_pos == 1 && lead_char == "0" && (c == "b" || c == "B"))
                    num_kind = lec_pkg::KIND_BIN;
                else if (tok_pos == 1 && lead_char == "0" && (c == "x" || c == "X"))
                    num_kind = lec_pkg::KIND_HEX;
                else
                    tok_good = 1'b0;
            lec_pkg::KIND_BIN:
                if (c == "0" || c == "1")
                    acc = {acc[62:0], c[0]};
                else
                    tok_good = 1'b0;
            default:
            begin
                nib = nibble_of(c);
                if (nib >= 0)
                    acc = {acc[59:0], 4'(nib)};
                else
                    tok_good = 1'b0;
            end
        endcase
    endtask

    task automatic scan_operator_char(logic [7:0] c);
        if (tok_pos == 0)
        begin
            case (c)
                "<":     oper = lec_pkg::OP_WAIT_LT;
                ">":     oper = lec_pkg::OP_WAIT_GT;
                "|":     oper = lec_pkg::OP_OR;
                "&":     oper = lec_pkg::OP_AND;
                "^":     oper = lec_pkg::OP_XOR;
                "%":     oper = lec_pkg::OP_MOD;
                "+":     oper = lec_pkg::OP_ADD;
                "-":     oper = lec_pkg::OP_SUB;
                "*":     oper = lec_pkg::OP_MUL;
                "/":     oper = lec_pkg::OP_DIV;
                default: oper = lec_pkg::OP_NONE;
            endcase
        end
        else if (tok_pos == 1)
        begin
            if (oper == lec_pkg::OP_WAIT_LT && c == "<")
                oper = lec_pkg::OP_SHL;
            else if (oper == lec_pkg::OP_WAIT_GT && c == ">")
                oper = lec_pkg::OP_SHR;
        end
    endtask

    // Validate the finished number and leave its signed value in acc.
    function automatic bit number_valid();
        bit signed_lead;
        bit ok;
        signed_lead = (lead_char == "-" || lead_char == "+");
        ok = tok_good;
        if (num_kind == lec_pkg::KIND_DEC)
            ok = ok && (tok_pos > (signed_lead ? 1 : 0));
        else if (num_kind == lec_pkg::KIND_BIN)
            ok = ok && tok_pos >= 3 && tok_pos <= 66;
        else if (num_kind == lec_pkg::KIND_HEX)
            ok = ok && tok_pos >= 3;
        if (num_kind == lec_pkg::KIND_ZERO)
            acc = '0;
        if (neg)
            acc = -acc;
        return ok;
    endfunction

    task automatic close_token();
        if (tok_count == 1)
        begin
            if (number_valid())
                lhs = acc;
            else if (first_err == lec_pkg::ST_OK)
                first_err = lec_pkg::ST_FIRST;
        end
        else if (tok_count == 2)
        begin
            if ((oper == lec_pkg::OP_NONE || oper >= lec_pkg::OP_WAIT_LT)
                && first_err == lec_pkg::ST_OK)
                first_err = lec_pkg::ST_OPER;
        end
        else if (tok_count == 3)
        begin
            if (!number_valid() && first_err == lec_pkg::ST_OK)
                first_err = lec_pkg::ST_SECOND;
        end
        in_tok = 1'b0;
    endtask

    function automatic calc_result_t evaluate_expr();
        calc_result_t r;
        logic [63:0] ua, ub, q, sra;
        bit na, nb;
        r   = '0;
        na  = lhs[63];
        nb  = acc[63];
        ua  = na ? -lhs : lhs;
        ub  = nb ? -acc : acc;
        sra = $signed(lhs) >>> acc[5:0];
        if (tok_count != 1 && tok_count != 3)
            r.status = lec_pkg::ST_COUNT;
        else if (first_err != lec_pkg::ST_OK)
            r.status = first_err;
        else if (tok_count == 1)
            r.value = lhs;
        else
        begin
            case (oper)
                lec_pkg::OP_SHL: r.value = (acc >= 64) ? '0 : lhs << acc[5:0];
                lec_pkg::OP_SHR: r.value = (acc >= 64) ? {64{na}} : sra;
                lec_pkg::OP_OR:  r.value = lhs | acc;
                lec_pkg::OP_AND: r.value = lhs & acc;
                lec_pkg::OP_XOR: r.value = lhs ^ acc;
                lec_pkg::OP_ADD: r.value = lhs + acc;
                lec_pkg::OP_SUB: r.value = lhs - acc;
                lec_pkg::OP_MUL: r.value = lhs * acc;
                lec_pkg::OP_DIV:
                    if (ub == 0)
                        r.status = lec_pkg::ST_DIVZERO;
                    else
                    begin
                        q = ua / ub;
                        r.value = (na != nb) ? -q : q;
                    end
                default:
                    if (ub == 0)
                        r.status = lec_pkg::ST_DIVZERO;
                    else
                    begin
                        q = ua % ub;
                        r.value = na ? -q : q;
                    end
            endcase
        end
        return r;
    endfunction

    // Advance the predictor by one accepted beat; queue a result on last.
    task automatic predict_char(logic [7:0] c, logic fin);
        if (c == lec_pkg::CH_SPACE || c == lec_pkg::CH_NL)
        begin
            if (in_tok)
                close_token();
        end
        else
        begin
            if (!in_tok)
            begin
                in_tok = 1'b1;
                if (tok_count < 4)
                    tok_count++;
                tok_pos   = '0;
                num_kind  = lec_pkg::KIND_DEC;
                tok_good  = 1'b1;
                neg       = 1'b0;
                acc       = '0;
                lead_char = '0;
            end
            if (tok_count == 1 || tok_count == 3)
                scan_number_char(c);
            else if (tok_count == 2)
                scan_operator_char(c);
            if (tok_pos < lec_pkg::POS_MAX)
                tok_pos++;
        end
        if (fin)
        begin
            if (in_tok)
                close_token();
            results_due.push_back(evaluate_expr());
            expr_reset();
        end
    endtask

    // Send one beat: starts and ends at a falling edge, handshake seen at a rise.
    task automatic send_beat(logic [7:0] c, logic fin);
        int n;
        n = 0;
        if (!calm)
            while ($urandom_range(99) < 16)
                n++;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        predict_char(c, fin);
        @(negedge clk);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], i == txt.len() - 1);
    endtask

    function automatic string rand_digits(int n, int base);
        string s;
        string hexset;
        s = "";
        hexset = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++)
        begin
            if (base == 2)
                s = {s, string'(8'("0" + $urandom_range(1)))};
            else if (base == 16)
                s = {s, string'(hexset[$urandom_range(21)])};
            else
                s = {s, string'(8'("0" + $urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string rand_number();
        int pick;
        string s;
        string pre;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            s = {string'(8'("1" + $urandom_range(8))), rand_digits($urandom_range(20), 10)};
            if ($urandom_range(3) == 0)
            begin
                if ($urandom_range(1))
                    pre = "-";
                else
                    pre = "+";
                s = {pre, s};
            end
        end
        else if (pick < 50)
        begin
            if ($urandom_range(1))
                pre = "0b";
            else
                pre = "0B";
            s = {pre, rand_digits($urandom_range(1, 66), 2)};
        end
        else if (pick < 65)
        begin
            if ($urandom_range(1))
                pre = "0x";
            else
                pre = "0X";
            s = {pre, rand_digits($urandom_range(1, 20), 16)};
        end
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0: s = "0";
                1: s = "-0";
                2: s = "+0";
                default: s = "1";
            endcase
        end
        else if (pick < 85)
            s = string'(8'("0" + $urandom_range(9)));
        else
        begin
            // Broken number: random bytes that are never separators
            s = "";
            for (int i = 0; i <= $urandom_range(4); i++)
            begin
                pick = $urandom_range(255);
                if (pick == lec_pkg::CH_SPACE || pick == lec_pkg::CH_NL)
                    pick = 8'h80 | pick;
                s = {s, string'(8'(pick))};
            end
        end
        return s;
    endfunction

    function automatic string rand_operator();
        string ops[12] = '{"<<", ">>", "|", "&", "^", "%", "+", "-", "*", "/", "<", "<>"};
        if ($urandom_range(19) == 0)
            return "@";
        return ops[$urandom_range(11)];
    endfunction

    function automatic string rand_gap();
        string s;
        if ($urandom_range(3) == 0)
            s = "\n";
        else
            s = " ";
        if ($urandom_range(5) == 0)
            s = {s, " "};
        return s;
    endfunction

    // Directed expressions with the expected result where it is obvious
    typedef struct {
        string       txt;
        bit          typed;
        logic [63:0] value;
        logic [2:0]  status;
    } directed_row_t;

    directed_row_t directed[] = '{
        '{"0", 1, 64'd0, lec_pkg::ST_OK},
        '{"-0", 1, 64'd0, lec_pkg::ST_OK},
        '{"+", 1, 64'd0, lec_pkg::ST_FIRST},
        '{"9223372036854775807", 1, 64'h7FFFFFFFFFFFFFFF, lec_pkg::ST_OK},
        '{"-9223372036854775808", 1, 64'h8000000000000000, lec_pkg::ST_OK},
        '{"18446744073709551617", 0, 64'd0, lec_pkg::ST_OK},
        '{"0xFFFFFFFFFFFFFFFF", 1, 64'hFFFFFFFFFFFFFFFF, lec_pkg::ST_OK},
        '{"0b1111111111111111111111111111111111111111111111111111111111111111",
          1, 64'hFFFFFFFFFFFFFFFF, lec_pkg::ST_OK},
        '{"0b10000000000000000000000000000000000000000000000000000000000000000",
          1, 64'd0, lec_pkg::ST_FIRST},
        '{"007", 1, 64'd0, lec_pkg::ST_FIRST},
        '{" ", 1, 64'd0, lec_pkg::ST_COUNT},
        '{"1 +", 1, 64'd0, lec_pkg::ST_COUNT},
        '{"1 ? 2", 1, 64'd0, lec_pkg::ST_OPER},
        '{"1 + x", 1, 64'd0, lec_pkg::ST_SECOND},
        '{"5 / 0", 1, 64'd0, lec_pkg::ST_DIVZERO},
        '{"5 % -0", 1, 64'd0, lec_pkg::ST_DIVZERO},
        '{"-9223372036854775808 / -1", 1, 64'h8000000000000000, lec_pkg::ST_OK},
        '{"-9223372036854775808 % -1", 1, 64'd0, lec_pkg::ST_OK},
        '{"1 << 64", 1, 64'd0, lec_pkg::ST_OK},
        '{"-5 >> -1", 1, 64'hFFFFFFFFFFFFFFFF, lec_pkg::ST_OK},
        '{"-7 % 3", 0, 64'd0, lec_pkg::ST_OK},
        '{"0xAb | 0B11 & 6 ^ 9", 1, 64'd0, lec_pkg::ST_COUNT},
        '{"3 ^ 5\n", 0, 64'd0, lec_pkg::ST_OK},
        '{"6 * -7", 0, 64'd0, lec_pkg::ST_OK},
        '{"100 - 1", 0, 64'd0, lec_pkg::ST_OK}
    };

    // Result checker
    always @(posedge clk)
    begin
        calc_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value  = m_tdata[63:0];
            got.status = m_tdata[66:64];
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d", got.value, got.status);
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want || m_tdata[71:67] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h status=%0d, got %h status=%0d",
                                 want.value, want.status, got.value, got.status);
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    // Long receiver hold-off, counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (cycles == 1500);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400)
            @(negedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        string txt;
        string lead;
        string tail;
        directed_row_t row;
        int sent;
        mismatches = 0;
        calm       = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        rst_n      = 1'b0;
        expr_reset();
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            row = directed[i];
            send_text(row.txt);
            // Replace the predicted row with the typed-in one where given
            if (row.typed)
            begin
                void'(results_due.pop_back());
                results_due.push_back('{value: row.value, status: row.status});
            end
        end
        s_tvalid <= 1'b0;

        // Pause until every result has come back
        wait (results_due.size() == 0);
        @(negedge clk);

        sent = 0;
        while (sent < 1150)
        begin
            calm = (sent >= 400 && sent < 600);
            case ($urandom_range(9))
                0:       txt = rand_number();
                1:
                begin
                    txt = "";
                    for (int i = 0; i <= $urandom_range(8); i++)
                        txt = {txt, string'(8'($urandom_range(255)))};
                end
                2:       txt = {rand_number(), rand_gap(), rand_operator(), rand_gap(),
                                rand_number(), rand_gap(), rand_number()};
                default:
                begin
                    lead = "";
                    tail = "";
                    if ($urandom_range(4) == 0)
                        lead = " ";
                    if ($urandom_range(4) == 0)
                        tail = "\n";
                    txt = {lead, rand_number(), rand_gap(), rand_operator(), rand_gap(),
                           rand_number(), tail};
                end
            endcase
            send_text(txt);
            sent += txt.len();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        wait (results_due.size() == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        failed = (mismatches != 0) || (results_due.size() != 0);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lec_pkg.sv
rtl/core/lec_ctrl.sv
rtl/core/lec_dp.sv
rtl/core/literal_expression_calculator.sv
tb/tb_literal_expression_calculator.sv
